@@ rtl/smmm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smmm_pkg: shared types and constants
// Widths, limits and the stream summary word passed from the front end to
// the mean divider.
// ----------------------------------------------------------------------------
package smmm_pkg;

    localparam int MAX_ITEMS   = 65536;
    localparam int SAMPLE_W    = 32;
    localparam int CNT_W       = 17;
    localparam int IDX_W       = 16;
    localparam int SUM_W       = 48;
    localparam int FRAC_W      = 8;
    localparam int MEAN_W      = 40;
    localparam int DVD_W       = SUM_W + FRAC_W;
    localparam int STEP_W      = $clog2(DVD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic signed [SAMPLE_W-1:0] min_value;
        logic [IDX_W-1:0]           min_position;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [IDX_W-1:0]           max_position;
        logic [SUM_W-1:0]           sum;
        logic                       dropped;
    } t_summary;

    typedef struct packed {
        logic [CNT_W-1:0]           item_count;
        logic signed [SAMPLE_W-1:0] min_value;
        logic [IDX_W-1:0]           min_position;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [IDX_W-1:0]           max_position;
        logic signed [MEAN_W-1:0]   mean_q8;
        logic                       too_long;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/smmm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smmm_front: running statistics accumulator
// Takes one sample a cycle while i_accept is high, tracks count, extremes with
// first index and a 48-bit sum; the last sample of a stream pushes a summary.
// ----------------------------------------------------------------------------
module smmm_front import smmm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last_item,
    output      logic                       o_push,
    output      t_summary                   o_summary
);

    logic [CNT_W-1:0]           r_count,   n_count;
    logic signed [SAMPLE_W-1:0] r_min,     n_min;
    logic [IDX_W-1:0]           r_min_idx, n_min_idx;
    logic signed [SAMPLE_W-1:0] r_max,     n_max;
    logic [IDX_W-1:0]           r_max_idx, n_max_idx;
    logic [SUM_W-1:0]           r_sum,     n_sum;
    logic                       r_drop,    n_drop;

    always_comb begin
        n_count   = r_count;
        n_min     = r_min;
        n_min_idx = r_min_idx;
        n_max     = r_max;
        n_max_idx = r_max_idx;
        n_sum     = r_sum;
        n_drop    = r_drop;
        if (i_accept) begin
            if (r_count < CNT_W'(MAX_ITEMS)) begin
                if (r_count == '0) begin
                    n_min     = i_sample;
                    n_max     = i_sample;
                    n_min_idx = '0;
                    n_max_idx = '0;
                end else begin
                    if (i_sample < r_min) begin
                        n_min     = i_sample;
                        n_min_idx = r_count[IDX_W-1:0];
                    end
                    if (i_sample > r_max) begin
                        n_max     = i_sample;
                        n_max_idx = r_count[IDX_W-1:0];
                    end
                end
                n_sum   = r_sum + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
                n_count = r_count + CNT_W'(1);
            end else begin
                n_drop = 1'b1;
            end
        end
        o_push                 = i_accept & i_last_item;
        o_summary.count        = n_count;
        o_summary.min_value    = n_min;
        o_summary.min_position = n_min_idx;
        o_summary.max_value    = n_max;
        o_summary.max_position = n_max_idx;
        o_summary.sum          = n_sum;
        o_summary.dropped      = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count   <= '0;
            r_min     <= '0;
            r_min_idx <= '0;
            r_max     <= '0;
            r_max_idx <= '0;
            r_sum     <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_min     <= n_min;
            r_min_idx <= n_min_idx;
            r_max     <= n_max;
            r_max_idx <= n_max_idx;
            r_sum     <= n_sum;
            r_drop    <= n_drop;
        end
    end

endmodule
`default_nettype wire

@@ rtl/smmm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smmm_queue: summary word queue
// Short register queue between the accumulator and the mean divider.
// ----------------------------------------------------------------------------
module smmm_queue import smmm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_summary i_data,
    input  wire logic     i_pop,
    output      logic     o_full,
    output      logic     o_empty,
    output      t_summary o_data
);

    t_summary          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt,    n_cnt;
    logic              do_push, do_pop;

    assign o_full   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign do_push  = i_push & ~o_full;
    assign do_pop   = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/smmm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smmm_back: mean divider and result register
// Restoring divide of |sum| * 256 by the count, one quotient bit a cycle,
// then sign fix and load of the result register.
// ----------------------------------------------------------------------------
module smmm_back import smmm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_empty,
    input  wire t_summary i_q_data,
    output      logic     o_q_pop,
    input  wire logic     i_pop,
    output      logic     o_empty,
    output      t_result  o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WAIT
    } t_state;

    t_state              r_state, n_state;
    t_summary            r_sum_word, n_sum_word;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [MEAN_W-1:0]   r_quo, n_quo;
    logic                r_neg, n_neg;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_diff;
    logic [SUM_W-1:0]    mag;
    logic [MEAN_W-1:0]   mean_val;

    assign o_empty  = ~r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_sum_word  = r_sum_word;
        n_step      = r_step;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;

        mag      = i_q_data.sum[SUM_W-1] ? (SUM_W'(0) - i_q_data.sum) : i_q_data.sum;
        rem_sh   = {r_rem, r_dvd[DVD_W-1]};
        rem_diff = rem_sh - {1'b0, r_sum_word.count};
        mean_val = '0;
        if (r_sum_word.count != '0) begin
            mean_val = r_neg ? (MEAN_W'(0) - r_quo) : r_quo;
        end

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop    = 1'b1;
                    n_sum_word = i_q_data;
                    n_neg      = i_q_data.sum[SUM_W-1];
                    n_dvd      = {mag, FRAC_W'(0)};
                    n_rem      = '0;
                    n_quo      = '0;
                    n_step     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                if (!rem_diff[CNT_W]) begin
                    n_rem = rem_diff[CNT_W-1:0];
                    n_quo = {r_quo[MEAN_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[CNT_W-1:0];
                    n_quo = {r_quo[MEAN_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_out_valid || i_pop) begin
                    n_out.item_count   = r_sum_word.count;
                    n_out.min_value    = r_sum_word.min_value;
                    n_out.min_position = r_sum_word.min_position;
                    n_out.max_value    = r_sum_word.max_value;
                    n_out.max_position = r_sum_word.max_position;
                    n_out.mean_q8      = mean_val;
                    n_out.too_long     = r_sum_word.dropped;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_sum_word <= n_sum_word;
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_quo      <= n_quo;
        r_neg      <= n_neg;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

@@ rtl/stream_min_max_mean.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stream_min_max_mean: running min, max and mean over a sample stream
// Channel  Direction  Handshake       Word
// input    in         push / full     i_sample, i_last_item
// result   out        empty / pop     o_item_count .. o_too_long
//
// One sample per cycle is taken while full is low; the accumulator adds no stall.
// A stream's last sample queues a summary word; the divider makes one quotient
// bit a cycle, then loads the result register before taking the next word.
// full rises only when the two-entry summary queue is full.
// Synchronous active-low reset clears counts, queue and result valid.
// ----------------------------------------------------------------------------
module stream_min_max_mean import smmm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output      logic                       full,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last_item,
    output      logic                       empty,
    input  wire logic                       pop,
    output      logic [CNT_W-1:0]           o_item_count,
    output      logic signed [SAMPLE_W-1:0] o_min_value,
    output      logic [IDX_W-1:0]           o_min_position,
    output      logic signed [SAMPLE_W-1:0] o_max_value,
    output      logic [IDX_W-1:0]           o_max_position,
    output      logic signed [MEAN_W-1:0]   o_mean_q8,
    output      logic                       o_too_long
);

    logic     accept;
    logic     f_push;
    t_summary f_summary;
    logic     q_full, q_empty, q_pop;
    t_summary q_data;
    t_result  result;

    assign full   = q_full;
    assign accept = push & ~q_full;

    smmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_last_item (i_last_item),
        .o_push      (f_push),
        .o_summary   (f_summary)
    );

    smmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_summary),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    smmm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_item_count   = result.item_count;
    assign o_min_value    = result.min_value;
    assign o_min_position = result.min_position;
    assign o_max_value    = result.max_value;
    assign o_max_position = result.max_position;
    assign o_mean_q8      = result.mean_q8;
    assign o_too_long     = result.too_long;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stream_min_max_mean
// Streams of signed samples go in through the push / full side. A model in
// the bench folds each accepted sample into its own running count, min, max,
// positions, sum and drop flag. On the last sample it queues the summary
// word it expects. Words taken through empty / pop are checked field by
// field, in order, against that queue.
// Directed streams cover extremes, ties, rounding of the mean and
// back-pressure. Random streams of varied length and value spread follow.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import smmm_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RUN_LIMIT_NS   = 15_000_000;
    localparam int RANDOM_SAMPLES = 1300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] MOST_POS = ~MOST_NEG;

    typedef enum int {
        STYLE_WIDE,
        STYLE_NEAR,
        STYLE_EDGE,
        STYLE_SPREAD
    } t_sample_style;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_last_item;
    logic                       empty;
    logic                       pop;
    logic [CNT_W-1:0]           o_item_count;
    logic signed [SAMPLE_W-1:0] o_min_value;
    logic [IDX_W-1:0]           o_min_position;
    logic signed [SAMPLE_W-1:0] o_max_value;
    logic [IDX_W-1:0]           o_max_position;
    logic signed [MEAN_W-1:0]   o_mean_q8;
    logic                       o_too_long;

    // running statistics of the stream in flight
    int unsigned                run_count   = 0;
    logic signed [SAMPLE_W-1:0] run_min     = '0;
    logic [IDX_W-1:0]           run_min_at  = '0;
    logic signed [SAMPLE_W-1:0] run_max     = '0;
    logic [IDX_W-1:0]           run_max_at  = '0;
    logic [SUM_W-1:0]           run_sum     = '0;
    logic                       run_dropped = 1'b0;

    t_result stats_due[$];
    int      mismatch_count = 0;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit result_hold  = 1'b0;
    int hold_len     = 0;

    stream_min_max_mean uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_sample       (i_sample),
        .i_last_item    (i_last_item),
        .empty          (empty),
        .pop            (pop),
        .o_item_count   (o_item_count),
        .o_min_value    (o_min_value),
        .o_min_position (o_min_position),
        .o_max_value    (o_max_value),
        .o_max_position (o_max_position),
        .o_mean_q8      (o_mean_q8),
        .o_too_long     (o_too_long)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("** stream_min_max_mean: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [MEAN_W-1:0] q8_mean(input logic [SUM_W-1:0] sum,
                                                         input int unsigned count);
        logic [SUM_W-1:0] mag;
        logic [63:0]      quot;
        mag = sum[SUM_W-1] ? -sum : sum;
        if (count == 0)
            return '0;
        quot = {8'd0, mag, 8'd0} / 64'(count);
        if (sum[SUM_W-1])
            quot = -quot;
        return quot[MEAN_W-1:0];
    endfunction

    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        t_result summary;
        if (run_count < MAX_ITEMS) begin
            if (run_count == 0) begin
                run_min    = value;
                run_max    = value;
                run_min_at = '0;
                run_max_at = '0;
            end else begin
                if (value < run_min) begin
                    run_min    = value;
                    run_min_at = IDX_W'(run_count);
                end
                if (value > run_max) begin
                    run_max    = value;
                    run_max_at = IDX_W'(run_count);
                end
            end
            run_sum   = run_sum + {{(SUM_W-SAMPLE_W){value[SAMPLE_W-1]}}, value};
            run_count = run_count + 1;
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            summary.item_count   = CNT_W'(run_count);
            summary.min_value    = run_min;
            summary.min_position = run_min_at;
            summary.max_value    = run_max;
            summary.max_position = run_max_at;
            summary.mean_q8      = q8_mean(run_sum, run_count);
            summary.too_long     = run_dropped;
            stats_due.push_back(summary);
            run_count   = 0;
            run_min     = '0;
            run_min_at  = '0;
            run_max     = '0;
            run_max_at  = '0;
            run_sum     = '0;
            run_dropped = 1'b0;
        end
    endtask

    // call right after a rising edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        logic was_full;
        push        <= 1'b1;
        i_sample    <= value;
        i_last_item <= last;
        do begin
            @(negedge i_clk);
            was_full = full;
            @(posedge i_clk);
        end while (was_full);
        absorb_sample(value, last);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_value(input t_sample_style style,
                                                              input int centre);
        case (style)
            STYLE_WIDE:   return $urandom;
            STYLE_NEAR:   return centre + int'($urandom_range(0, 6)) - 3;
            STYLE_EDGE: begin
                case ($urandom_range(0, 6))
                    0: return MOST_NEG;
                    1: return MOST_NEG + 1;
                    2: return MOST_POS;
                    3: return MOST_POS - 1;
                    4: return -1;
                    5: return 1;
                    default: return 0;
                endcase
            end
            default:      return centre + int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // receive side: sample at the falling edge, check and pick pop at the rising edge
    initial begin : result_checker
        t_result got;
        t_result want;
        logic    took;
        int      rx_stall;
        rx_stall = 0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            took = pop && !empty;
            got  = '{o_item_count, o_min_value, o_min_position, o_max_value,
                     o_max_position, o_mean_q8, o_too_long};
            @(posedge i_clk);
            if (took) begin
                if (stats_due.size() == 0) begin
                    flag_mismatch("word with none pending", '0, 64'(got.item_count));
                end else begin
                    want = stats_due.pop_front();
                    if (got.item_count !== want.item_count)
                        flag_mismatch("item_count", want.item_count, got.item_count);
                    if (got.min_value !== want.min_value)
                        flag_mismatch("min_value", want.min_value, got.min_value);
                    if (got.min_position !== want.min_position)
                        flag_mismatch("min_position", want.min_position, got.min_position);
                    if (got.max_value !== want.max_value)
                        flag_mismatch("max_value", want.max_value, got.max_value);
                    if (got.max_position !== want.max_position)
                        flag_mismatch("max_position", want.max_position, got.max_position);
                    if (got.mean_q8 !== want.mean_q8)
                        flag_mismatch("mean_q8", want.mean_q8, got.mean_q8);
                    if (got.too_long !== want.too_long)
                        flag_mismatch("too_long", want.too_long, got.too_long);
                end
            end
            if (result_hold) begin
                pop <= 1'b0;
            end else if (rx_stall > 0) begin
                pop <= 1'b0;
                rx_stall--;
            end else begin
                pop <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    // when hold_len is set, hold the receiver off, then clear hold_len
    initial begin : result_holdoff
        forever begin
            wait (hold_len != 0);
            @(negedge i_clk);
            result_hold = 1'b1;
            repeat (hold_len) @(negedge i_clk);
            result_hold = 1'b0;
            hold_len    = 0;
        end
    end

    task automatic test_single_extremes();
        send_sample(MOST_NEG, 1'b1);
        send_sample(MOST_POS, 1'b1);
        send_sample(0, 1'b1);
        send_sample(-1, 1'b1);
    endtask

    task automatic test_ties_and_order();
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        send_sample(3, 1'b0);
        send_sample(3, 1'b0);
        send_sample(9, 1'b0);
        send_sample(9, 1'b1);
        send_sample(-7, 1'b0);
        send_sample(-7, 1'b1);
    endtask

    task automatic test_mean_rounding();
        send_sample(-1, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b1);
        send_sample(1, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b1);
        send_sample(MOST_POS, 1'b0);
        send_sample(MOST_NEG, 1'b1);
        send_sample(-5, 1'b0);
        send_sample(2, 1'b1);
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_len   = 400;
        for (int k = 0; k < 12; k++)
            send_sample($urandom, 1'b1);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int            sent;
        int            len;
        int            pick;
        int            centre;
        t_sample_style style;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            style  = t_sample_style'($urandom_range(0, 3));
            centre = $urandom;
            pick   = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 8);
            else if (pick < 19)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 150);
            tx_idle_on = ($urandom_range(0, 5) != 0);
            rx_idle_on = ($urandom_range(0, 5) != 0);
            for (int k = 0; k < len; k++)
                send_sample(pick_value(style, centre), k == len - 1);
            sent += len;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_sample    <= '0;
        i_last_item <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_extremes();
        test_ties_and_order();
        test_mean_rounding();
        test_backpressure();
        test_random_streams();

        push <= 1'b0;
        wait (stats_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && stats_due.size() == 0)
            $display("** stream_min_max_mean: PASSED **");
        else
            $display("** stream_min_max_mean: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
rtl/smmm_pkg.sv
rtl/smmm_front.sv
rtl/smmm_queue.sv
rtl/smmm_back.sv
rtl/stream_min_max_mean.sv
sim/testbench.sv
